// ----- rtl/core/arp_pkg.sv -----
// shared types, constants and the pearson permutation table for the archive record parser
package arp_pkg;

    // record framing
    localparam logic [7:0] MAGIC_VALUE = 8'h42;
    localparam int         MODE_BYTES  = 3;
    localparam int         PLEN_BYTES  = 2;
    localparam int         CLEN_BYTES  = 6;
    localparam int         DIR_BIT     = 14;

    // field widths
    localparam int MODE_W  = 24;
    localparam int PLEN_W  = 16;
    localparam int CLEN_W  = 48;
    localparam int COUNT_W = 48;

    // parser phase
    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_MODE    = 3'd1,
        PH_PLEN    = 3'd2,
        PH_CLEN    = 3'd3,
        PH_PATH    = 3'd4,
        PH_CONTENT = 3'd5,
        PH_HASH    = 3'd6,
        PH_HALT    = 3'd7
    } phase_t;

    // event reported for each item
    typedef enum logic [2:0] {
        EV_HEADER      = 3'd0,
        EV_HEADER_DONE = 3'd1,
        EV_PATH        = 3'd2,
        EV_CONTENT     = 3'd3,
        EV_OK          = 3'd4,
        EV_BAD_MAGIC   = 3'd5,
        EV_MISMATCH    = 3'd6,
        EV_IGNORED     = 3'd7
    } event_t;

    // one result item as it leaves the parser
    typedef struct packed {
        event_t              kind;
        logic [7:0]          data;
        logic [MODE_W-1:0]   mode;
        logic [PLEN_W-1:0]   name_len;
        logic [CLEN_W-1:0]   body_len;
        logic [7:0]          hash;
        logic                dir;
    } arp_result_t;

    // fixed pearson permutation
    localparam logic [7:0] PERM_ROM [0:255] = '{
        8'd241, 8'd18,  8'd181, 8'd164, 8'd92,  8'd237, 8'd100, 8'd216,
        8'd183, 8'd107, 8'd2,   8'd12,  8'd43,  8'd246, 8'd90,  8'd143,
        8'd251, 8'd49,  8'd228, 8'd134, 8'd215, 8'd20,  8'd193, 8'd172,
        8'd140, 8'd227, 8'd148, 8'd118, 8'd57,  8'd72,  8'd119, 8'd174,
        8'd78,  8'd14,  8'd97,  8'd3,   8'd208, 8'd252, 8'd11,  8'd195,
        8'd31,  8'd28,  8'd121, 8'd206, 8'd149, 8'd23,  8'd83,  8'd154,
        8'd223, 8'd109, 8'd89,  8'd10,  8'd178, 8'd243, 8'd42,  8'd194,
        8'd221, 8'd131, 8'd212, 8'd94,  8'd205, 8'd240, 8'd161, 8'd7,
        8'd62,  8'd214, 8'd222, 8'd219, 8'd1,   8'd84,  8'd95,  8'd58,
        8'd103, 8'd60,  8'd33,  8'd111, 8'd188, 8'd218, 8'd186, 8'd166,
        8'd146, 8'd189, 8'd201, 8'd155, 8'd68,  8'd145, 8'd44,  8'd163,
        8'd69,  8'd196, 8'd115, 8'd231, 8'd61,  8'd157, 8'd165, 8'd213,
        8'd139, 8'd112, 8'd173, 8'd191, 8'd142, 8'd88,  8'd106, 8'd250,
        8'd8,   8'd127, 8'd26,  8'd126, 8'd0,   8'd96,  8'd52,  8'd182,
        8'd113, 8'd38,  8'd242, 8'd48,  8'd204, 8'd160, 8'd15,  8'd54,
        8'd158, 8'd192, 8'd81,  8'd125, 8'd245, 8'd239, 8'd101, 8'd17,
        8'd136, 8'd110, 8'd24,  8'd53,  8'd132, 8'd117, 8'd102, 8'd153,
        8'd226, 8'd4,   8'd203, 8'd199, 8'd16,  8'd249, 8'd211, 8'd167,
        8'd55,  8'd255, 8'd254, 8'd116, 8'd122, 8'd13,  8'd236, 8'd93,
        8'd144, 8'd86,  8'd59,  8'd76,  8'd150, 8'd162, 8'd207, 8'd77,
        8'd176, 8'd32,  8'd124, 8'd171, 8'd29,  8'd45,  8'd30,  8'd67,
        8'd184, 8'd51,  8'd22,  8'd105, 8'd170, 8'd253, 8'd180, 8'd187,
        8'd130, 8'd156, 8'd98,  8'd159, 8'd220, 8'd40,  8'd133, 8'd135,
        8'd114, 8'd147, 8'd75,  8'd73,  8'd210, 8'd21,  8'd129, 8'd39,
        8'd138, 8'd91,  8'd41,  8'd235, 8'd47,  8'd185, 8'd9,   8'd82,
        8'd64,  8'd87,  8'd244, 8'd50,  8'd74,  8'd233, 8'd175, 8'd247,
        8'd120, 8'd6,   8'd169, 8'd85,  8'd66,  8'd104, 8'd80,  8'd71,
        8'd230, 8'd152, 8'd225, 8'd34,  8'd248, 8'd198, 8'd63,  8'd168,
        8'd179, 8'd141, 8'd137, 8'd5,   8'd19,  8'd79,  8'd232, 8'd128,
        8'd202, 8'd46,  8'd70,  8'd37,  8'd209, 8'd217, 8'd123, 8'd27,
        8'd177, 8'd25,  8'd56,  8'd65,  8'd229, 8'd36,  8'd197, 8'd234,
        8'd108, 8'd35,  8'd151, 8'd238, 8'd200, 8'd224, 8'd99,  8'd190
    };

endpackage

// ----- rtl/core/arp_hash.sv -----
// one pearson hash step: xor with the byte, then permutation lookup
module arp_hash (
    input  logic [7:0] hash_in,
    input  logic [7:0] byte_in,
    output logic [7:0] hash_out
);

    logic [7:0] rom_index;

    // table index and lookup
    assign rom_index = hash_in ^ byte_in;
    assign hash_out  = arp_pkg::PERM_ROM[rom_index];

endmodule

// ----- rtl/core/arp_parse.sv -----
// record parser state machine: field assembly, length counting and hash check
module arp_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           byte_in,
    output arp_pkg::arp_result_t result
);

    arp_pkg::phase_t                  phase_reg, phase_next;
    logic [arp_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [arp_pkg::MODE_W-1:0]       mode_reg,  mode_next;
    logic [arp_pkg::PLEN_W-1:0]       plen_reg,  plen_next;
    logic [arp_pkg::CLEN_W-1:0]       clen_reg,  clen_next;
    logic [7:0]                       hash_reg,  hash_next;
    arp_pkg::event_t                  kind;

    logic [7:0]                       mix_src;
    logic [7:0]                       mixed;
    logic [arp_pkg::COUNT_W-1:0]      count_inc;
    logic [arp_pkg::COUNT_W-1:0]      count_dec;
    logic                             dir_now;
    logic                             mode_done;
    logic                             plen_done;
    logic                             clen_done;
    logic                             hash_match;

    // hash restarts from zero on the magic byte
    assign mix_src = (phase_reg == arp_pkg::PH_MAGIC) ? 8'd0 : hash_reg;

    arp_hash u_hash (
        .hash_in  (mix_src),
        .byte_in  (byte_in),
        .hash_out (mixed)
    );

    // shared counter arithmetic and field checks
    assign count_inc  = count_reg + arp_pkg::COUNT_W'(1);
    assign count_dec  = count_reg - arp_pkg::COUNT_W'(1);
    assign dir_now    = mode_reg[arp_pkg::DIR_BIT];
    assign mode_done  = count_inc >= arp_pkg::COUNT_W'(arp_pkg::MODE_BYTES);
    assign plen_done  = count_inc >= arp_pkg::COUNT_W'(arp_pkg::PLEN_BYTES);
    assign clen_done  = count_inc >= arp_pkg::COUNT_W'(arp_pkg::CLEN_BYTES);
    assign hash_match = dir_now || (byte_in == hash_reg);

    // record field and hash updates
    always_comb
    begin
        mode_next = mode_reg;
        plen_next = plen_reg;
        clen_next = clen_reg;
        hash_next = hash_reg;
        unique case (phase_reg)
            arp_pkg::PH_MAGIC:
            begin
                mode_next = '0;
                plen_next = '0;
                clen_next = '0;
                hash_next = mixed;
            end
            arp_pkg::PH_MODE:
            begin
                mode_next = {mode_reg[arp_pkg::MODE_W-9:0], byte_in};
                hash_next = mixed;
            end
            arp_pkg::PH_PLEN:
            begin
                plen_next = {plen_reg[arp_pkg::PLEN_W-9:0], byte_in};
                hash_next = mixed;
            end
            arp_pkg::PH_CLEN:
            begin
                clen_next = {clen_reg[arp_pkg::CLEN_W-9:0], byte_in};
                hash_next = mixed;
            end
            arp_pkg::PH_PATH, arp_pkg::PH_CONTENT:
            begin
                hash_next = mixed;
            end
            default:
            begin
                hash_next = hash_reg;
            end
        endcase
    end

    // next phase and length counter
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        unique case (phase_reg)
            arp_pkg::PH_MAGIC:
            begin
                count_next = '0;
                phase_next = (byte_in == arp_pkg::MAGIC_VALUE) ? arp_pkg::PH_MODE
                                                               : arp_pkg::PH_HALT;
            end
            arp_pkg::PH_MODE:
            begin
                if (mode_done)
                begin
                    phase_next = arp_pkg::PH_PLEN;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            arp_pkg::PH_PLEN:
            begin
                if (plen_done)
                begin
                    phase_next = arp_pkg::PH_CLEN;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            arp_pkg::PH_CLEN:
            begin
                if (!clen_done)
                begin
                    count_next = count_inc;
                end
                else if (plen_reg != '0)
                begin
                    phase_next = arp_pkg::PH_PATH;
                    count_next = arp_pkg::COUNT_W'(plen_reg);
                end
                else if (!dir_now && clen_next != '0)
                begin
                    phase_next = arp_pkg::PH_CONTENT;
                    count_next = clen_next;
                end
                else
                begin
                    phase_next = arp_pkg::PH_HASH;
                    count_next = '0;
                end
            end
            arp_pkg::PH_PATH:
            begin
                count_next = count_dec;
                if (count_dec == '0)
                begin
                    // path finished: content next unless a directory or empty
                    if (!dir_now && clen_reg != '0)
                    begin
                        phase_next = arp_pkg::PH_CONTENT;
                        count_next = clen_reg;
                    end
                    else
                    begin
                        phase_next = arp_pkg::PH_HASH;
                    end
                end
            end
            arp_pkg::PH_CONTENT:
            begin
                count_next = count_dec;
                if (count_dec == '0)
                begin
                    phase_next = arp_pkg::PH_HASH;
                end
            end
            arp_pkg::PH_HASH:
            begin
                count_next = '0;
                phase_next = hash_match ? arp_pkg::PH_MAGIC : arp_pkg::PH_HALT;
            end
            arp_pkg::PH_HALT:
            begin
                phase_next = arp_pkg::PH_HALT;
            end
            default:
            begin
                phase_next = arp_pkg::PH_HALT;
            end
        endcase
    end

    // event decode
    always_comb
    begin
        unique case (phase_reg)
            arp_pkg::PH_MAGIC:
            begin
                kind = (byte_in == arp_pkg::MAGIC_VALUE) ? arp_pkg::EV_HEADER
                                                         : arp_pkg::EV_BAD_MAGIC;
            end
            arp_pkg::PH_MODE, arp_pkg::PH_PLEN:
            begin
                kind = arp_pkg::EV_HEADER;
            end
            arp_pkg::PH_CLEN:
            begin
                kind = clen_done ? arp_pkg::EV_HEADER_DONE : arp_pkg::EV_HEADER;
            end
            arp_pkg::PH_PATH:
            begin
                kind = arp_pkg::EV_PATH;
            end
            arp_pkg::PH_CONTENT:
            begin
                kind = arp_pkg::EV_CONTENT;
            end
            arp_pkg::PH_HASH:
            begin
                kind = hash_match ? arp_pkg::EV_OK : arp_pkg::EV_MISMATCH;
            end
            default:
            begin
                kind = arp_pkg::EV_IGNORED;
            end
        endcase
    end

    // result fields reflect the state after this item
    assign result.kind     = kind;
    assign result.data     = byte_in;
    assign result.mode     = mode_next;
    assign result.name_len = plen_next;
    assign result.body_len = clen_next;
    assign result.hash     = hash_next;
    assign result.dir      = mode_next[arp_pkg::DIR_BIT];

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= arp_pkg::PH_MAGIC;
            count_reg <= '0;
            mode_reg  <= '0;
            plen_reg  <= '0;
            clen_reg  <= '0;
            hash_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            mode_reg  <= mode_next;
            plen_reg  <= plen_next;
            clen_reg  <= clen_next;
            hash_reg  <= hash_next;
        end
    end

`ifndef SYNTHESIS
    // an error is sticky until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == arp_pkg::PH_HALT) |=> (phase_reg == arp_pkg::PH_HALT))
        else $error("parser left the halted phase");

    // a hash byte always closes the record one way or the other
    a_hash_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == arp_pkg::PH_HASH)
        |=> (phase_reg == arp_pkg::PH_MAGIC || phase_reg == arp_pkg::PH_HALT))
        else $error("hash byte did not end the record");

    // good magic starts the mode field with a clean counter
    a_magic_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == arp_pkg::PH_MAGIC && byte_in == arp_pkg::MAGIC_VALUE)
        |=> (phase_reg == arp_pkg::PH_MODE && count_reg == '0 && mode_reg == '0))
        else $error("magic byte did not open a record");
`endif

endmodule

// ----- rtl/core/archive_record_parser_checker_unit.sv -----
// top level of the archive record parser: input register, parser and result register
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  input    | in_valid / in_stall  | stream_byte
//  output   | out_valid / out_stall| event_kind, data_byte, record_mode, name_length,
//           |                      | body_length, running_hash, is_directory
//
// one item per cycle sustained while out_stall is low; a taken item reaches the output through
// the input register, then parser logic into the result register
// reset clears the parser to expect a magic byte, clears all fields and empties both stages
// a stalled result holds the parser; the input register still takes one more item,
// after which in_stall follows out_stall
module archive_record_parser_checker_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  stream_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [7:0]  data_byte,
    output logic [23:0] record_mode,
    output logic [15:0] name_length,
    output logic [47:0] body_length,
    output logic [7:0]  running_hash,
    output logic        is_directory
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 out_valid_reg;
    arp_pkg::arp_result_t res_reg;
    arp_pkg::arp_result_t res_next;
    logic                 advance;
    logic                 in_take;

    // stage control
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= stream_byte;
        end
    end

    // parser
    arp_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .byte_in (in_byte_reg),
        .result  (res_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // output ports
    assign out_valid    = out_valid_reg;
    assign event_kind   = res_reg.kind;
    assign data_byte    = res_reg.data;
    assign record_mode  = res_reg.mode;
    assign name_length  = res_reg.name_len;
    assign body_length  = res_reg.body_len;
    assign running_hash = res_reg.hash;
    assign is_directory = res_reg.dir;

`ifndef SYNTHESIS
    // a parsed item always lands in the result register
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("parsed item did not reach the result register");

    // a held input item keeps its byte until parsed
    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("held input item was lost or changed");

    // an empty input register never pushes back
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> !in_stall)
        else $error("stall raised with an empty input register");
`endif

endmodule

// ----- test/tb_archive_record_parser_checker_unit.sv -----
// self-checking testbench for the archive record parser with a built-in byte-level predictor
module tb_archive_record_parser_checker_unit;

    // record framing as the predictor sees it
    localparam logic [7:0] RECORD_MAGIC     = 8'h42;
    localparam int         MODE_FIELD_BYTES = 3;
    localparam int         PLEN_FIELD_BYTES = 2;
    localparam int         CLEN_FIELD_BYTES = 6;
    localparam int         DIR_MODE_BIT     = 14;
    localparam int         REPORT_LIMIT     = 10;

    // pearson permutation used for the running record hash
    localparam logic [7:0] PEARSON_PERM [0:255] = '{
        8'd241, 8'd18,  8'd181, 8'd164, 8'd92,  8'd237, 8'd100, 8'd216,
        8'd183, 8'd107, 8'd2,   8'd12,  8'd43,  8'd246, 8'd90,  8'd143,
        8'd251, 8'd49,  8'd228, 8'd134, 8'd215, 8'd20,  8'd193, 8'd172,
        8'd140, 8'd227, 8'd148, 8'd118, 8'd57,  8'd72,  8'd119, 8'd174,
        8'd78,  8'd14,  8'd97,  8'd3,   8'd208, 8'd252, 8'd11,  8'd195,
        8'd31,  8'd28,  8'd121, 8'd206, 8'd149, 8'd23,  8'd83,  8'd154,
        8'd223, 8'd109, 8'd89,  8'd10,  8'd178, 8'd243, 8'd42,  8'd194,
        8'd221, 8'd131, 8'd212, 8'd94,  8'd205, 8'd240, 8'd161, 8'd7,
        8'd62,  8'd214, 8'd222, 8'd219, 8'd1,   8'd84,  8'd95,  8'd58,
        8'd103, 8'd60,  8'd33,  8'd111, 8'd188, 8'd218, 8'd186, 8'd166,
        8'd146, 8'd189, 8'd201, 8'd155, 8'd68,  8'd145, 8'd44,  8'd163,
        8'd69,  8'd196, 8'd115, 8'd231, 8'd61,  8'd157, 8'd165, 8'd213,
        8'd139, 8'd112, 8'd173, 8'd191, 8'd142, 8'd88,  8'd106, 8'd250,
        8'd8,   8'd127, 8'd26,  8'd126, 8'd0,   8'd96,  8'd52,  8'd182,
        8'd113, 8'd38,  8'd242, 8'd48,  8'd204, 8'd160, 8'd15,  8'd54,
        8'd158, 8'd192, 8'd81,  8'd125, 8'd245, 8'd239, 8'd101, 8'd17,
        8'd136, 8'd110, 8'd24,  8'd53,  8'd132, 8'd117, 8'd102, 8'd153,
        8'd226, 8'd4,   8'd203, 8'd199, 8'd16,  8'd249, 8'd211, 8'd167,
        8'd55,  8'd255, 8'd254, 8'd116, 8'd122, 8'd13,  8'd236, 8'd93,
        8'd144, 8'd86,  8'd59,  8'd76,  8'd150, 8'd162, 8'd207, 8'd77,
        8'd176, 8'd32,  8'd124, 8'd171, 8'd29,  8'd45,  8'd30,  8'd67,
        8'd184, 8'd51,  8'd22,  8'd105, 8'd170, 8'd253, 8'd180, 8'd187,
        8'd130, 8'd156, 8'd98,  8'd159, 8'd220, 8'd40,  8'd133, 8'd135,
        8'd114, 8'd147, 8'd75,  8'd73,  8'd210, 8'd21,  8'd129, 8'd39,
        8'd138, 8'd91,  8'd41,  8'd235, 8'd47,  8'd185, 8'd9,   8'd82,
        8'd64,  8'd87,  8'd244, 8'd50,  8'd74,  8'd233, 8'd175, 8'd247,
        8'd120, 8'd6,   8'd169, 8'd85,  8'd66,  8'd104, 8'd80,  8'd71,
        8'd230, 8'd152, 8'd225, 8'd34,  8'd248, 8'd198, 8'd63,  8'd168,
        8'd179, 8'd141, 8'd137, 8'd5,   8'd19,  8'd79,  8'd232, 8'd128,
        8'd202, 8'd46,  8'd70,  8'd37,  8'd209, 8'd217, 8'd123, 8'd27,
        8'd177, 8'd25,  8'd56,  8'd65,  8'd229, 8'd36,  8'd197, 8'd234,
        8'd108, 8'd35,  8'd151, 8'd238, 8'd200, 8'd224, 8'd99,  8'd190
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  stream_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  event_kind;
    logic [7:0]  data_byte;
    logic [23:0] record_mode;
    logic [15:0] name_length;
    logic [47:0] body_length;
    logic [7:0]  running_hash;
    logic        is_directory;

    // parser state mirrored by the predictor
    arp_pkg::phase_t ph = arp_pkg::PH_MAGIC;
    logic [47:0] remaining = '0;
    logic [23:0] cur_mode = '0;
    logic [15:0] cur_name_len = '0;
    logic [47:0] cur_body_len = '0;
    logic [7:0]  cur_hash = '0;
    logic        halted = 1'b0;

    arp_pkg::arp_result_t awaited_events [$];
    int unsigned items_sent = 0;
    int unsigned failures = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;

    archive_record_parser_checker_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .stream_byte  (stream_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_kind   (event_kind),
        .data_byte    (data_byte),
        .record_mode  (record_mode),
        .name_length  (name_length),
        .body_length  (body_length),
        .running_hash (running_hash),
        .is_directory (is_directory)
    );

    // clock
    always #5 clk = ~clk;

    // random back-pressure on the result side
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    function automatic void pearson_mix(input logic [7:0] b);
        cur_hash = PEARSON_PERM[cur_hash ^ b];
    endfunction

    // directories and empty bodies go straight to the hash byte
    function automatic void open_content();
        if (!cur_mode[DIR_MODE_BIT] && cur_body_len != '0)
        begin
            ph = arp_pkg::PH_CONTENT;
            remaining = cur_body_len;
        end
        else
        begin
            ph = arp_pkg::PH_HASH;
            remaining = '0;
        end
    endfunction

    // step the mirrored parser by one taken byte and queue the event it reports
    function automatic void advance_parser(input logic [7:0] b);
        arp_pkg::arp_result_t r;
        arp_pkg::event_t      kind;
        kind = arp_pkg::EV_IGNORED;
        if (!halted)
        begin
            case (ph)
                arp_pkg::PH_MAGIC:
                begin
                    cur_mode = '0;
                    cur_name_len = '0;
                    cur_body_len = '0;
                    cur_hash = '0;
                    pearson_mix(b);
                    remaining = '0;
                    if (b != RECORD_MAGIC)
                    begin
                        halted = 1'b1;
                        ph = arp_pkg::PH_HALT;
                        kind = arp_pkg::EV_BAD_MAGIC;
                    end
                    else
                    begin
                        ph = arp_pkg::PH_MODE;
                        kind = arp_pkg::EV_HEADER;
                    end
                end
                arp_pkg::PH_MODE:
                begin
                    cur_mode = {cur_mode[15:0], b};
                    pearson_mix(b);
                    kind = arp_pkg::EV_HEADER;
                    remaining = remaining + 1;
                    if (remaining >= MODE_FIELD_BYTES)
                    begin
                        ph = arp_pkg::PH_PLEN;
                        remaining = '0;
                    end
                end
                arp_pkg::PH_PLEN:
                begin
                    cur_name_len = {cur_name_len[7:0], b};
                    pearson_mix(b);
                    kind = arp_pkg::EV_HEADER;
                    remaining = remaining + 1;
                    if (remaining >= PLEN_FIELD_BYTES)
                    begin
                        ph = arp_pkg::PH_CLEN;
                        remaining = '0;
                    end
                end
                arp_pkg::PH_CLEN:
                begin
                    cur_body_len = {cur_body_len[39:0], b};
                    pearson_mix(b);
                    kind = arp_pkg::EV_HEADER;
                    remaining = remaining + 1;
                    if (remaining >= CLEN_FIELD_BYTES)
                    begin
                        kind = arp_pkg::EV_HEADER_DONE;
                        if (cur_name_len != '0)
                        begin
                            ph = arp_pkg::PH_PATH;
                            remaining = 48'(cur_name_len);
                        end
                        else
                        begin
                            open_content();
                        end
                    end
                end
                arp_pkg::PH_PATH:
                begin
                    pearson_mix(b);
                    kind = arp_pkg::EV_PATH;
                    remaining = remaining - 1;
                    if (remaining == '0)
                    begin
                        open_content();
                    end
                end
                arp_pkg::PH_CONTENT:
                begin
                    pearson_mix(b);
                    kind = arp_pkg::EV_CONTENT;
                    remaining = remaining - 1;
                    if (remaining == '0)
                    begin
                        ph = arp_pkg::PH_HASH;
                    end
                end
                arp_pkg::PH_HASH:
                begin
                    remaining = '0;
                    if (cur_mode[DIR_MODE_BIT] || b == cur_hash)
                    begin
                        kind = arp_pkg::EV_OK;
                        ph = arp_pkg::PH_MAGIC;
                    end
                    else
                    begin
                        kind = arp_pkg::EV_MISMATCH;
                        halted = 1'b1;
                        ph = arp_pkg::PH_HALT;
                    end
                end
                default:
                begin
                    kind = arp_pkg::EV_IGNORED;
                end
            endcase
        end
        r.kind = kind;
        r.data = b;
        r.mode = cur_mode;
        r.name_len = cur_name_len;
        r.body_len = cur_body_len;
        r.hash = cur_hash;
        r.dir = cur_mode[DIR_MODE_BIT];
        awaited_events.push_back(r);
    endfunction

    function automatic void note_failure(input string what);
        failures++;
        if (failures <= REPORT_LIMIT)
        begin
            $display("%0t: %s", $realtime, what);
        end
    endfunction

    // compare every accepted result with the oldest awaited event
    always @(posedge clk)
    begin
        arp_pkg::arp_result_t got;
        arp_pkg::arp_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.kind = arp_pkg::event_t'(event_kind);
            got.data = data_byte;
            got.mode = record_mode;
            got.name_len = name_length;
            got.body_len = body_length;
            got.hash = running_hash;
            got.dir = is_directory;
            if (awaited_events.size() == 0)
            begin
                note_failure($sformatf("unexpected result kind=%0d data=%02h",
                                       got.kind, got.data));
            end
            else
            begin
                want = awaited_events.pop_front();
                if (got.kind !== want.kind || got.data !== want.data ||
                    got.mode !== want.mode || got.name_len !== want.name_len ||
                    got.body_len !== want.body_len || got.hash !== want.hash ||
                    got.dir !== want.dir)
                begin
                    note_failure($sformatf({"mismatch exp kind=%0d data=%02h mode=%06h ",
                        "nlen=%04h blen=%012h hash=%02h dir=%0b / got kind=%0d data=%02h ",
                        "mode=%06h nlen=%04h blen=%012h hash=%02h dir=%0b"},
                        want.kind, want.data, want.mode, want.name_len, want.body_len,
                        want.hash, want.dir, got.kind, got.data, got.mode, got.name_len,
                        got.body_len, got.hash, got.dir));
                end
            end
        end
    end

    // offer one item, with random idle cycles first, and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        stream_byte <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        advance_parser(b);
        items_sent++;
    endtask

    function automatic logic [7:0] body_byte(input bit extremes, input logic [47:0] k);
        if (extremes)
        begin
            return k[0] ? 8'hFF : 8'h00;
        end
        return 8'($urandom);
    endfunction

    // one whole record; for a file the hash byte is taken from the mirrored running hash, or spoiled on request
    task automatic send_record(input logic [23:0] mode, input logic [15:0] plen,
                               input logic [47:0] clen, input bit spoil_hash,
                               input bit extremes);
        logic [47:0] k;
        send_byte(RECORD_MAGIC);
        for (k = 0; k < MODE_FIELD_BYTES; k++)
        begin
            send_byte(mode[8 * (MODE_FIELD_BYTES - 1 - k) +: 8]);
        end
        for (k = 0; k < PLEN_FIELD_BYTES; k++)
        begin
            send_byte(plen[8 * (PLEN_FIELD_BYTES - 1 - k) +: 8]);
        end
        for (k = 0; k < CLEN_FIELD_BYTES; k++)
        begin
            send_byte(clen[8 * (CLEN_FIELD_BYTES - 1 - k) +: 8]);
        end
        for (k = 0; k < 48'(plen); k++)
        begin
            send_byte(body_byte(extremes, k));
        end
        if (!mode[DIR_MODE_BIT])
        begin
            for (k = 0; k < clen; k++)
            begin
                send_byte(body_byte(extremes, k));
            end
        end
        // directories skip the check, so any hash byte will do
        if (mode[DIR_MODE_BIT])
        begin
            send_byte(8'($urandom));
        end
        else if (spoil_hash)
        begin
            send_byte(cur_hash ^ 8'($urandom_range(1, 255)));
        end
        else
        begin
            send_byte(cur_hash);
        end
    endtask

    // header only, path and content both empty
    task automatic test_empty_record();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        send_record(24'h000000, 16'h0000, 48'h0, 1'b0, 1'b0);
    endtask

    // plain files with path, content or both, bytes at their extremes
    task automatic test_file_records();
        sender_idle_pct = 19;
        receiver_stall_pct = 19;
        send_record(24'h0081A4, 16'h0003, 48'h4, 1'b0, 1'b1);
        send_record(24'hFFBFFF, 16'h0000, 48'h1, 1'b0, 1'b1);
        send_record(24'h000000, 16'h0002, 48'h0, 1'b0, 1'b1);
    endtask

    // directories ignore the content length and the hash value
    task automatic test_directory_records();
        sender_idle_pct = 19;
        receiver_stall_pct = 19;
        send_record(24'hFFFFFF, 16'h0000, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0);
        send_record(24'h004000, 16'h0002, 48'h3, 1'b0, 1'b1);
    endtask

    // well-formed records of random shape under each idling pattern
    task automatic test_random_records();
        int unsigned stage;
        int unsigned stop_at;
        logic [23:0] mode;
        logic [15:0] plen;
        logic [47:0] clen;
        for (stage = 0; stage < 4; stage++)
        begin
            case (stage)
                0:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 76;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 76;
                end
                default:
                begin
                    sender_idle_pct = 19;
                    receiver_stall_pct = 19;
                end
            endcase
            stop_at = items_sent + 250;
            while (items_sent < stop_at)
            begin
                mode = 24'($urandom);
                if ($urandom_range(0, 19) == 0)
                begin
                    plen = 16'($urandom_range(7, 300));
                end
                else
                begin
                    plen = 16'($urandom_range(0, 6));
                end
                if (mode[DIR_MODE_BIT])
                begin
                    clen = ($urandom_range(0, 3) == 0) ? 48'h0 : {16'($urandom), $urandom};
                end
                else if ($urandom_range(0, 19) == 0)
                begin
                    clen = 48'($urandom_range(9, 300));
                end
                else
                begin
                    clen = 48'($urandom_range(0, 8));
                end
                send_record(mode, plen, clen, 1'b0, 1'b0);
            end
        end
    endtask

    // one error per run since it sticks until reset; then everything is ignored
    task automatic test_sticky_error();
        int unsigned k;
        logic [7:0]  b;
        sender_idle_pct = 19;
        receiver_stall_pct = 19;
        if ($urandom_range(0, 1) == 1)
        begin
            do
            begin
                b = 8'($urandom);
            end
            while (b == RECORD_MAGIC);
            send_byte(b);
        end
        else
        begin
            send_record(24'($urandom) & ~(24'd1 << DIR_MODE_BIT), 16'h0002, 48'h3,
                        1'b1, 1'b0);
        end
        send_record(24'h000000, 16'h0001, 48'h1, 1'b0, 1'b0);
        for (k = 0; k < 20; k++)
        begin
            send_byte(8'($urandom));
        end
    endtask

    // run limit
    initial
    begin
        #2000000;
        $display("tb_archive_record_parser_checker_unit failed");
        $finish;
    end

    initial
    begin
        int unsigned guard;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        test_empty_record();
        test_file_records();
        test_directory_records();
        test_random_records();
        test_sticky_error();

        // drain the pipeline
        @(negedge clk);
        in_valid <= 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        guard = 0;
        while (awaited_events.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (awaited_events.size() != 0)
        begin
            note_failure($sformatf("%0d results never arrived", awaited_events.size()));
        end
        if (failures == 0)
        begin
            $display("tb_archive_record_parser_checker_unit passed");
        end
        else
        begin
            $display("tb_archive_record_parser_checker_unit failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/arp_pkg.sv
rtl/core/arp_hash.sv
rtl/core/arp_parse.sv
rtl/core/archive_record_parser_checker_unit.sv
test/tb_archive_record_parser_checker_unit.sv
